@@ rtl/core/obss_pkg.sv @@
`default_nettype none

package obss_pkg;

  localparam int BUF_DEPTH  = 32;
  localparam int BUF_AW     = $clog2(BUF_DEPTH);
  localparam int CNT_W      = 6;
  localparam int SUM_W      = CNT_W + 1;
  localparam int ID_W       = 64;
  localparam int Q_DEPTH    = 2;
  localparam int Q_AW       = $clog2(Q_DEPTH);
  localparam int Q_CW       = $clog2(Q_DEPTH + 1);
  localparam int IN_DATA_W  = 3 * ID_W;
  localparam int OUT_FLD_W  = 2 * ID_W + 2 + CNT_W + 1;
  localparam int OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;
  localparam int RAM_W      = 2 * ID_W;

  typedef enum logic [1:0] {
    MODE_WAIT,
    MODE_HAVE,
    MODE_SYNCED,
    MODE_BROKEN
  } mode_t;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_APPLY,
    ACT_RESYNC
  } action_t;

  typedef enum logic {
    CMD_DELTA,
    CMD_SNAPSHOT
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_CLOSE
  } state_t;

  typedef struct packed {
    cmd_t            cmd;
    logic [ID_W-1:0] first_id;
    logic [ID_W-1:0] final_id;
    logic [ID_W-1:0] snap_id;
  } item_t;

  typedef struct packed {
    action_t          action;
    logic [ID_W-1:0]  applied_first_id;
    logic [ID_W-1:0]  applied_final_id;
    mode_t            mode_after;
    logic [CNT_W-1:0] buffered_count;
    logic             overflow;
    logic             last_of_run;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/core/obss_ram.sv @@
`default_nettype none

module obss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/obss_front.sv @@
`default_nettype none

module obss_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               tvalid,
  output logic                               tready,
  input  logic [obss_pkg::IN_DATA_W-1:0]     tdata,
  input  logic [0:0]                         tuser,
  output logic                               item_valid,
  output obss_pkg::item_t                    item,
  input  logic                               item_take
);

  import obss_pkg::*;

  item_t           ent [Q_DEPTH];
  item_t           in_item;
  logic [Q_AW-1:0] wptr;
  logic [Q_AW-1:0] rptr;
  logic [Q_CW-1:0] cnt;
  logic            push;
  logic            take;

  assign tready     = (cnt != Q_CW'(Q_DEPTH));
  assign item_valid = (cnt != '0);
  assign item       = ent[rptr];
  assign push       = tvalid && tready;
  assign take       = item_valid && item_take;

  always_comb begin
    in_item.cmd      = tuser[0] ? CMD_SNAPSHOT : CMD_DELTA;
    in_item.first_id = tdata[ID_W-1:0];
    in_item.final_id = tdata[2*ID_W-1:ID_W];
    in_item.snap_id  = tdata[3*ID_W-1:2*ID_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == Q_AW'(Q_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (take) begin
        rptr <= (rptr == Q_AW'(Q_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !take) begin
        cnt <= cnt + 1'b1;
      end else if (take && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wptr] <= in_item;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/obss_back.sv @@
`default_nettype none

module obss_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  obss_pkg::item_t   item,
  output logic              item_take,
  output logic              m_valid,
  input  logic              m_ready,
  output obss_pkg::result_t m_result
);

  import obss_pkg::*;

  state_t            state;
  state_t            state_next;
  mode_t             mode;
  mode_t             mode_next;
  logic [ID_W-1:0]   last_id;
  logic [ID_W-1:0]   last_id_next;
  logic [BUF_AW-1:0] head;
  logic [BUF_AW-1:0] head_next;
  logic [CNT_W-1:0]  fill;
  logic [CNT_W-1:0]  fill_next;
  logic              first;
  logic              first_next;

  logic              o_valid;
  result_t           o_res;
  result_t           res_next;
  logic              emit;

  logic              ram_we;
  logic              ram_re;
  logic [BUF_AW-1:0] tail;
  logic [SUM_W-1:0]  tail_sum;
  logic [RAM_W-1:0]  ram_rdata;
  logic [ID_W-1:0]   hd_first;
  logic [ID_W-1:0]   hd_final;
  logic [ID_W-1:0]   next_id;
  logic [BUF_AW-1:0] head_inc;
  logic              can_emit;
  logic              stale;
  logic              drain_ok;
  logic              delta_cover;
  logic              buf_full;

  assign can_emit    = !o_valid || m_ready;
  assign next_id     = last_id + 64'd1;
  assign hd_first    = ram_rdata[ID_W-1:0];
  assign hd_final    = ram_rdata[RAM_W-1:ID_W];
  assign stale       = first && (hd_final <= last_id);
  assign drain_ok    = first ? ((hd_first <= next_id) && (hd_final >= next_id))
                             : (hd_first == next_id);
  assign delta_cover = (item.first_id <= next_id) && (item.final_id >= next_id);
  assign buf_full    = (fill >= CNT_W'(BUF_DEPTH));
  assign head_inc    = (head == BUF_AW'(BUF_DEPTH - 1)) ? '0 : head + 1'b1;
  assign tail_sum    = SUM_W'(head) + SUM_W'(fill);
  assign tail        = (tail_sum >= SUM_W'(BUF_DEPTH))
                     ? BUF_AW'(tail_sum - SUM_W'(BUF_DEPTH)) : tail_sum[BUF_AW-1:0];

  obss_ram #(
    .WIDTH(RAM_W),
    .DEPTH(BUF_DEPTH)
  ) u_buf (
    .clk  (clk),
    .we   (ram_we),
    .waddr(tail),
    .wdata({item.final_id, item.first_id}),
    .re   (ram_re),
    .raddr(head),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (item_valid && item.cmd == CMD_SNAPSHOT) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = (fill != '0) ? ST_EVAL : ST_CLOSE;
      end
      ST_EVAL: begin
        if (stale) begin
          state_next = ST_READ;
        end else if (can_emit) begin
          state_next = drain_ok ? ST_READ : ST_IDLE;
        end
      end
      ST_CLOSE: begin
        if (can_emit) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    mode_next    = mode;
    last_id_next = last_id;
    head_next    = head;
    fill_next    = fill;
    first_next   = first;
    item_take    = 1'b0;
    emit         = 1'b0;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    res_next     = '0;
    case (state)
      ST_IDLE: begin
        if (item_valid && item.cmd == CMD_SNAPSHOT) begin
          item_take    = 1'b1;
          last_id_next = item.snap_id;
          mode_next    = MODE_HAVE;
          first_next   = 1'b1;
        end else if (item_valid && can_emit) begin
          item_take            = 1'b1;
          emit                 = 1'b1;
          res_next.last_of_run = 1'b1;
          if (mode == MODE_SYNCED && delta_cover) begin
            last_id_next              = item.final_id;
            res_next.action           = ACT_APPLY;
            res_next.applied_first_id = item.first_id;
            res_next.applied_final_id = item.final_id;
            res_next.mode_after       = mode;
            res_next.buffered_count   = fill;
          end else begin
            mode_next       = (mode == MODE_SYNCED) ? MODE_BROKEN : mode;
            res_next.action = (mode == MODE_SYNCED || mode == MODE_BROKEN)
                            ? ACT_RESYNC : ACT_NONE;
            if (buf_full) begin
              mode_next               = MODE_BROKEN;
              res_next.action         = ACT_RESYNC;
              res_next.overflow       = 1'b1;
              res_next.buffered_count = fill;
            end else begin
              ram_we                  = 1'b1;
              fill_next               = fill + 1'b1;
              res_next.buffered_count = fill + 1'b1;
            end
            res_next.mode_after = mode_next;
          end
        end
      end
      ST_READ: begin
        ram_re = (fill != '0);
      end
      ST_EVAL: begin
        if (stale) begin
          head_next = head_inc;
          fill_next = fill - 1'b1;
        end else if (can_emit) begin
          emit = 1'b1;
          if (drain_ok) begin
            last_id_next              = hd_final;
            head_next                 = head_inc;
            fill_next                 = fill - 1'b1;
            first_next                = 1'b0;
            res_next.action           = ACT_APPLY;
            res_next.applied_first_id = hd_first;
            res_next.applied_final_id = hd_final;
            res_next.mode_after       = mode;
            res_next.buffered_count   = fill - 1'b1;
          end else begin
            mode_next               = MODE_BROKEN;
            res_next.action         = ACT_RESYNC;
            res_next.mode_after     = MODE_BROKEN;
            res_next.buffered_count = fill;
            res_next.last_of_run    = 1'b1;
          end
        end
      end
      ST_CLOSE: begin
        if (can_emit) begin
          emit                    = 1'b1;
          mode_next               = MODE_SYNCED;
          res_next.action         = ACT_NONE;
          res_next.mode_after     = MODE_SYNCED;
          res_next.buffered_count = fill;
          res_next.last_of_run    = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      mode    <= MODE_WAIT;
      last_id <= '0;
      head    <= '0;
      fill    <= '0;
      first   <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      state   <= state_next;
      mode    <= mode_next;
      last_id <= last_id_next;
      head    <= head_next;
      fill    <= fill_next;
      first   <= first_next;
      if (emit) begin
        o_valid <= 1'b1;
      end else if (m_ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      o_res <= res_next;
    end
  end

  assign m_valid  = o_valid;
  assign m_result = o_res;

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(BUF_DEPTH))
    else $error("buffer fill beyond depth");

  a_drain_no_grow: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |=> fill <= $past(fill))
    else $error("buffer grew during snapshot drain");

  a_eval_mode: assert property (@(posedge clk) disable iff (rst)
    state == ST_EVAL |-> mode == MODE_HAVE)
    else $error("drain step outside have-snapshot mode");

  a_overflow_word: assert property (@(posedge clk) disable iff (rst)
    o_valid && o_res.overflow |->
      o_res.action == ACT_RESYNC && o_res.mode_after == MODE_BROKEN)
    else $error("overflow word without resync and broken mode");

  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    item_take |-> state == ST_IDLE)
    else $error("item taken while draining");

endmodule

`default_nettype wire

@@ rtl/core/order_book_sequence_sync_unit.sv @@
// A delta word is registered in the input queue entry and then in the output result register.
// Throughput: one delta per cycle while the output is taken without stalls and no snapshot drains.
// A snapshot is first taken, then each buffered delta is walked with one buffer RAM read and one
// check; once the buffer is empty a closing word ends the run, and a gap ends it with a resync.
// Reset (rst, synchronous, active high) empties both queues and restores wait-for-snapshot mode.
`default_nettype none

module order_book_sequence_sync_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // Fields from bit 0: first_id, final_id, snapshot_last_id.
  input  logic [obss_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // Fields from bit 0: command.
  input  logic [0:0]                        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // Fields from bit 0: applied_first_id, applied_final_id, mode_after,
  // buffered_count, overflow, zero padding.
  output logic [obss_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // Fields from bit 0: action.
  output logic [1:0]                        m_axis_tuser,
  output logic                              m_axis_tlast
);

  import obss_pkg::*;

  logic    item_valid;
  item_t   item;
  logic    item_take;
  result_t res;

  obss_front u_front (
    .clk       (clk),
    .rst       (rst),
    .tvalid    (s_axis_tvalid),
    .tready    (s_axis_tready),
    .tdata     (s_axis_tdata),
    .tuser     (s_axis_tuser),
    .item_valid(item_valid),
    .item      (item),
    .item_take (item_take)
  );

  obss_back u_back (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item      (item),
    .item_take (item_take),
    .m_valid   (m_axis_tvalid),
    .m_ready   (m_axis_tready),
    .m_result  (res)
  );

  assign m_axis_tdata = {{(OUT_DATA_W - OUT_FLD_W){1'b0}}, res.overflow, res.buffered_count,
                         res.mode_after, res.applied_final_id, res.applied_first_id};
  assign m_axis_tuser = res.action;
  assign m_axis_tlast = res.last_of_run;

endmodule

`default_nettype wire
